@@ rtl/core/gms_pkg.sv @@
package gms_pkg;

    localparam int DIM_W     = 12;
    localparam int PIX_W     = 8;
    localparam int TAPS      = 9;
    localparam int TAP_W     = 4;
    localparam int RGB_SUM_W = 10;
    localparam int MEAN_SUM_W = 12;
    localparam int SQ_W      = 17;
    localparam int CFG_IDX_W = 2;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;
    localparam int DEF_COEF_BITS  = 4;

    localparam logic [DIM_W-1:0] DIM_RESET = 12'd512;
    localparam logic [PIX_W-1:0] PIX_MAX   = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_KERNEL_X     = 2'd2,
        CFG_KERNEL_Y     = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GREY,
        S_MCHK,
        S_MTAP,
        S_MWAIT,
        S_MWR,
        S_OCHK,
        S_OTAP,
        S_OWAIT,
        S_OSQ,
        S_OSTART,
        S_OROOT,
        S_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic done;
    } root_ctl_t;

    // floor(s/3) for s up to 765
    function automatic logic [PIX_W-1:0] div3(input logic [RGB_SUM_W-1:0] s);
        logic [RGB_SUM_W+10-1:0] p;
        p = {10'd0, s} * 20'd683;
        return p[PIX_W+11-1:11];
    endfunction

    // floor(s/9) for s up to 2295
    function automatic logic [PIX_W-1:0] div9(input logic [MEAN_SUM_W-1:0] s);
        logic [MEAN_SUM_W+13-1:0] p;
        p = {13'd0, s} * 25'd7282;
        return p[PIX_W+16-1:16];
    endfunction

    function automatic logic [1:0] tap_row(input logic [TAP_W-1:0] t);
        logic [1:0] r;
        case (t)
            4'd0, 4'd1, 4'd2: r = 2'd0;
            4'd3, 4'd4, 4'd5: r = 2'd1;
            default:          r = 2'd2;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] tap_col(input logic [TAP_W-1:0] t);
        logic [1:0] c;
        case (t)
            4'd0, 4'd3, 4'd6: c = 2'd0;
            4'd1, 4'd4, 4'd7: c = 2'd1;
            default:          c = 2'd2;
        endcase
        return c;
    endfunction

endpackage

@@ rtl/core/gms_isqrt.sv @@
module gms_isqrt
    import gms_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  root_ctl_t           ctl_in,
    input  logic [SQ_W-1:0]     value,
    output root_ctl_t           ctl_out,
    output logic [PIX_W-1:0]    root
);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic                big_reg, big_next;
    logic [2:0]          bit_reg, bit_next;
    logic [PIX_W-1:0]    root_reg, root_next;
    logic [SQ_W-2:0]     val_reg, val_next;
    logic [PIX_W-1:0]    cand;
    logic [2*PIX_W-1:0]  cand_sq;

    always_comb
    begin
        cand    = root_reg | (PIX_W'(1) << bit_reg);
        cand_sq = cand * cand;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        big_next  = big_reg;
        bit_next  = bit_reg;
        root_next = root_reg;
        val_next  = val_reg;
        if (ctl_in.start)
        begin
            busy_next = 1'b1;
            big_next  = value[SQ_W-1];
            bit_next  = 3'd7;
            root_next = '0;
            val_next  = value[SQ_W-2:0];
        end
        else if (busy_reg)
        begin
            if (cand_sq <= val_reg)
            begin
                root_next = cand;
            end
            bit_next = bit_reg - 3'd1;
            if (bit_reg == 3'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        big_reg  <= big_next;
        bit_reg  <= bit_next;
        root_reg <= root_next;
        val_reg  <= val_next;
    end

    // values of 2^16 and above have a root of at least 256
    assign root          = big_reg ? PIX_MAX : root_reg;
    assign ctl_out.done  = done_reg;
    assign ctl_out.start = busy_reg;

endmodule

@@ rtl/core/grey_mean_sobel_edge_pipeline.sv @@
// RGB pixels go in raster order, one per request, and come back as edge pixels
// (magnitude, clamped x and y responses, tlast on the last pixel of the frame)
// lagging about two lines plus two pixels behind; after the last pixel send
// drain requests (tuser=1) until the request with tlast has come out. A request
// takes longer for each 3x3 mean that it computes and for an output that it makes,
// which waits until the output register is free or being emptied; the last
// pixel of the frame computes the remaining line and two pixels of means at once.
// The cost is set by the single read port of each line memory, one 3x3 tap a
// cycle, and by the bit-serial square root. Writing frame_width or frame_height
// restarts the frame.
module grey_mean_sobel_edge_pipeline
    import gms_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int COEF_BITS  = DEF_COEF_BITS,
    localparam int KW    = TAPS * COEF_BITS,
    localparam int CFG_W = (KW > DIM_W) ? KW : DIM_W
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [23:0]          s_tdata,   // red, green, blue
    input  logic                 s_tuser,   // op
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata,   // grad_y, grad_x, edge_magnitude
    output logic                 m_tlast,   // frame_last
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int ADDR_W = $clog2(4 * MAX_WIDTH);
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int POS_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1) + 1;
    localparam int SUM_W  = ADDR_W + DIM_W + 2;
    localparam int ACC_W  = COEF_BITS + PIX_W + 5;

    // configuration
    logic [DIM_W-1:0] fw_reg, fh_reg;
    logic [KW-1:0]    kx_reg, ky_reg;
    logic             size_wr;
    logic [DIM_W-1:0] w_eff, h_eff;
    logic [POS_W-1:0] total_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg <= DIM_RESET;
            fh_reg <= DIM_RESET;
            kx_reg <= '0;
            ky_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_FRAME_WIDTH:  fw_reg <= cfg_data[DIM_W-1:0];
                CFG_FRAME_HEIGHT: fh_reg <= cfg_data[DIM_W-1:0];
                CFG_KERNEL_X:     kx_reg <= cfg_data[KW-1:0];
                CFG_KERNEL_Y:     ky_reg <= cfg_data[KW-1:0];
                default:          ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign size_wr   = cfg_valid && (cfg_idx_t'(cfg_index) == CFG_FRAME_WIDTH ||
                                     cfg_idx_t'(cfg_index) == CFG_FRAME_HEIGHT);

    always_comb
    begin
        if (fw_reg == '0)
            w_eff = DIM_W'(1);
        else if (32'(fw_reg) > 32'(MAX_WIDTH))
            w_eff = DIM_W'(MAX_WIDTH);
        else
            w_eff = fw_reg;
        if (fh_reg == '0)
            h_eff = DIM_W'(1);
        else if (32'(fh_reg) > 32'(MAX_HEIGHT))
            h_eff = DIM_W'(MAX_HEIGHT);
        else
            h_eff = fh_reg;
    end

    always_ff @(posedge clk)
    begin
        total_reg <= POS_W'(w_eff) * POS_W'(h_eff);
    end

    // control state
    state_t state_reg, state_next;
    logic [POS_W-1:0] n_reg, n_next, m_reg, m_next, o_reg, o_next;
    logic [DIM_W-1:0] mrow_reg, mrow_next, mcol_reg, mcol_next;
    logic [DIM_W-1:0] orow_reg, orow_next, ocol_reg, ocol_next;
    logic [TAP_W-1:0] tap_reg, tap_next, ptap_reg, ptap_next;
    logic             pend_reg, pend_next;
    logic             ov_reg, ov_next;

    // data
    logic                    op_reg, op_next;
    logic [PIX_W-1:0]        grey_reg, grey_next;
    logic [MEAN_SUM_W-1:0]   msum_reg, msum_next;
    logic signed [ACC_W-1:0] ax_reg, ax_next, ay_reg, ay_next;
    logic [PIX_W-1:0]        gx_reg, gx_next, gy_reg, gy_next;
    logic [23:0]             od_reg, od_next;
    logic                    ol_reg, ol_next;

    // memories
    logic [PIX_W-1:0]  grey_mem [DEPTH];
    logic [PIX_W-1:0]  mean_mem [DEPTH];
    logic [PIX_W-1:0]  grey_rd, mean_rd;
    logic              gw_en, mw_en, gr_en, mr_en;
    logic [ADDR_W-1:0] tap_addr;

    // handshakes and conditions
    logic             in_acc, out_load, n_ok, m_due, o_due, last_o;
    logic [POS_W:0]   m_lim, o_lim;
    logic [POS_W-1:0] lim_m, lim_o;
    root_ctl_t        rt_in, rt_out;
    logic [PIX_W-1:0] root;

    // tap geometry
    logic [1:0]        tj, ti;
    logic [DIM_W-1:0]  brow, bcol;
    logic [POS_W-1:0]  bpos;
    logic [DIM_W:0]    jw;
    logic [SUM_W-1:0]  addr_sum;
    logic              tap_in;
    logic [SQ_W-1:0]   sq_calc;

    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_load = (state_reg == S_OUT) && (!ov_reg || m_tready);

    always_comb
    begin
        m_lim  = {1'b0, m_reg} + (POS_W+1)'(w_eff) + (POS_W+1)'(2);
        o_lim  = {1'b0, o_reg} + (POS_W+1)'(w_eff) + (POS_W+1)'(2);
        lim_m  = ({1'b0, total_reg} < m_lim) ? total_reg : m_lim[POS_W-1:0];
        lim_o  = ({1'b0, total_reg} < o_lim) ? total_reg : o_lim[POS_W-1:0];
        n_ok   = n_reg < total_reg;
        m_due  = (m_reg < total_reg) && (n_reg >= lim_m);
        o_due  = (o_reg < total_reg) && (m_reg >= lim_o);
        last_o = (o_reg == total_reg - POS_W'(1));
    end

    always_comb
    begin
        tj = tap_row(tap_reg);
        ti = tap_col(tap_reg);
        if (state_reg == S_MTAP)
        begin
            brow = mrow_reg;
            bcol = mcol_reg;
            bpos = m_reg;
        end
        else
        begin
            brow = orow_reg;
            bcol = ocol_reg;
            bpos = o_reg;
        end
        case (tj)
            2'd0:    jw = '0;
            2'd1:    jw = {1'b0, w_eff};
            default: jw = {w_eff, 1'b0};
        endcase
        // raster position of the tap, wrapped to the ring depth
        addr_sum = SUM_W'(bpos[ADDR_W-1:0]) + SUM_W'(jw) + SUM_W'(ti)
                 - SUM_W'(w_eff) - SUM_W'(1);
        tap_addr = addr_sum[ADDR_W-1:0];
        tap_in   = !(tj == 2'd0 && brow == '0) &&
                   !(tj == 2'd2 && brow == h_eff - DIM_W'(1)) &&
                   !(ti == 2'd0 && bcol == '0) &&
                   !(ti == 2'd2 && bcol == w_eff - DIM_W'(1));
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (in_acc) state_next = S_GREY;
            S_GREY:   state_next = S_MCHK;
            S_MCHK:   state_next = m_due ? S_MTAP : S_OCHK;
            S_MTAP:   if (tap_reg == TAP_W'(TAPS - 1)) state_next = S_MWAIT;
            S_MWAIT:  state_next = S_MWR;
            S_MWR:    state_next = S_MCHK;
            S_OCHK:   state_next = o_due ? S_OTAP : S_IDLE;
            S_OTAP:   if (tap_reg == TAP_W'(TAPS - 1)) state_next = S_OWAIT;
            S_OWAIT:  state_next = S_OSQ;
            S_OSQ:    state_next = S_OSTART;
            S_OSTART: state_next = S_OROOT;
            S_OROOT:  if (rt_out.done) state_next = S_OUT;
            S_OUT:    if (out_load) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // outputs of the state machine
    always_comb
    begin
        gw_en       = (state_reg == S_GREY) && !op_reg && n_ok;
        mw_en       = (state_reg == S_MWR);
        gr_en       = (state_reg == S_MTAP) && tap_in;
        mr_en       = (state_reg == S_OTAP) && tap_in;
        rt_in.start = (state_reg == S_OSTART);
        rt_in.done  = 1'b0;
    end

    function automatic logic signed [ACC_W-1:0] tap_mul(
        input logic [KW-1:0] k, input logic [TAP_W-1:0] t, input logic [PIX_W-1:0] v);
        logic signed [COEF_BITS-1:0] c;
        logic signed [COEF_BITS+PIX_W:0] p;
        c = signed'(k[t*COEF_BITS +: COEF_BITS]);
        p = c * signed'({1'b0, v});
        return ACC_W'(p);
    endfunction

    always_comb
    begin
        sq_calc = SQ_W'(gx_reg) * SQ_W'(gx_reg) + SQ_W'(gy_reg) * SQ_W'(gy_reg);
    end

    // datapath and counters
    always_comb
    begin
        n_next    = n_reg;
        m_next    = m_reg;
        o_next    = o_reg;
        mrow_next = mrow_reg;
        mcol_next = mcol_reg;
        orow_next = orow_reg;
        ocol_next = ocol_reg;
        tap_next  = tap_reg;
        ptap_next = tap_reg;
        pend_next = 1'b0;
        op_next   = op_reg;
        grey_next = grey_reg;
        msum_next = msum_reg;
        ax_next   = ax_reg;
        ay_next   = ay_reg;
        gx_next   = gx_reg;
        gy_next   = gy_reg;
        od_next   = od_reg;
        ol_next   = ol_reg;
        ov_next   = ov_reg;

        if (m_tready)
            ov_next = 1'b0;

        if (in_acc)
        begin
            op_next   = s_tuser;
            grey_next = div3(RGB_SUM_W'(s_tdata[7:0]) + RGB_SUM_W'(s_tdata[15:8]) +
                             RGB_SUM_W'(s_tdata[23:16]));
        end

        if (gw_en)
            n_next = n_reg + POS_W'(1);

        if (state_reg == S_MCHK || state_reg == S_OCHK)
        begin
            tap_next  = '0;
            msum_next = '0;
            ax_next   = '0;
            ay_next   = '0;
        end

        if (state_reg == S_MTAP || state_reg == S_OTAP)
        begin
            tap_next  = tap_reg + TAP_W'(1);
            pend_next = tap_in;
        end

        // read data of the previous tap arrives now
        if (pend_reg && (state_reg == S_MTAP || state_reg == S_MWAIT))
            msum_next = msum_reg + MEAN_SUM_W'(grey_rd);
        if (pend_reg && (state_reg == S_OTAP || state_reg == S_OWAIT))
        begin
            ax_next = ax_reg + tap_mul(kx_reg, ptap_reg, mean_rd);
            ay_next = ay_reg + tap_mul(ky_reg, ptap_reg, mean_rd);
        end

        if (mw_en)
        begin
            m_next = m_reg + POS_W'(1);
            if (mcol_reg == w_eff - DIM_W'(1))
            begin
                mcol_next = '0;
                mrow_next = mrow_reg + DIM_W'(1);
            end
            else
                mcol_next = mcol_reg + DIM_W'(1);
        end

        if (state_reg == S_OSQ)
        begin
            if (ax_reg < 0)
                gx_next = '0;
            else if (ax_reg > ACC_W'(PIX_MAX))
                gx_next = PIX_MAX;
            else
                gx_next = ax_reg[PIX_W-1:0];
            if (ay_reg < 0)
                gy_next = '0;
            else if (ay_reg > ACC_W'(PIX_MAX))
                gy_next = PIX_MAX;
            else
                gy_next = ay_reg[PIX_W-1:0];
        end

        if (out_load)
        begin
            ov_next = 1'b1;
            od_next = {gy_reg, gx_reg, root};
            ol_next = last_o;
            if (last_o)
            begin
                n_next    = '0;
                m_next    = '0;
                o_next    = '0;
                mrow_next = '0;
                mcol_next = '0;
                orow_next = '0;
                ocol_next = '0;
            end
            else
            begin
                o_next = o_reg + POS_W'(1);
                if (ocol_reg == w_eff - DIM_W'(1))
                begin
                    ocol_next = '0;
                    orow_next = orow_reg + DIM_W'(1);
                end
                else
                    ocol_next = ocol_reg + DIM_W'(1);
            end
        end

        if (size_wr)
        begin
            n_next    = '0;
            m_next    = '0;
            o_next    = '0;
            mrow_next = '0;
            mcol_next = '0;
            orow_next = '0;
            ocol_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            n_reg     <= '0;
            m_reg     <= '0;
            o_reg     <= '0;
            mrow_reg  <= '0;
            mcol_reg  <= '0;
            orow_reg  <= '0;
            ocol_reg  <= '0;
            tap_reg   <= '0;
            pend_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            m_reg     <= m_next;
            o_reg     <= o_next;
            mrow_reg  <= mrow_next;
            mcol_reg  <= mcol_next;
            orow_reg  <= orow_next;
            ocol_reg  <= ocol_next;
            tap_reg   <= tap_next;
            pend_reg  <= pend_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptap_reg <= ptap_next;
        op_reg   <= op_next;
        grey_reg <= grey_next;
        msum_reg <= msum_next;
        ax_reg   <= ax_next;
        ay_reg   <= ay_next;
        gx_reg   <= gx_next;
        gy_reg   <= gy_next;
        od_reg   <= od_next;
        ol_reg   <= ol_next;
    end

    always_ff @(posedge clk)
    begin
        if (gw_en)
            grey_mem[n_reg[ADDR_W-1:0]] <= grey_reg;
        if (gr_en)
            grey_rd <= grey_mem[tap_addr];
    end

    always_ff @(posedge clk)
    begin
        if (mw_en)
            mean_mem[m_reg[ADDR_W-1:0]] <= div9(msum_reg);
        if (mr_en)
            mean_rd <= mean_mem[tap_addr];
    end

    // the root unit takes the sum of squares in the cycle it starts
    gms_isqrt u_isqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (rt_in),
        .value   (sq_calc),
        .ctl_out (rt_out),
        .root    (root)
    );

    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;
    assign m_tlast  = ol_reg;

endmodule
